@@ hw/rtl/iafdp_pkg.sv @@
// Shared types, codes and constants for the integer ALU.
package iafdp_pkg;

  localparam int DataWidth  = 64;
  localparam int CountWidth = 7;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_MOD = 5'd3,
    OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_NAND = 5'd7,
    OP_XNOR = 5'd8, OP_NOR = 5'd9, OP_SHL = 5'd10, OP_SHR = 5'd11,
    OP_POW = 5'd12, OP_FDIV = 5'd13, OP_LNAND = 5'd14, OP_LNOR = 5'd15,
    OP_LXOR = 5'd16, OP_LXNOR = 5'd17, OP_EQ = 5'd18, OP_NE = 5'd19,
    OP_LT = 5'd20, OP_LE = 5'd21, OP_GT = 5'd22, OP_GE = 5'd23,
    OP_DIV = 5'd24
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_SHIFT_RANGE = 2'd2, ST_NEEDS_FLOAT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_DONE
  } state_t;

  // Kind of iterative job for the shared unit.
  typedef enum logic [1:0] {
    K_MUL, K_DIV, K_POW
  } kind_t;

  typedef struct packed {
    logic  start;
    kind_t kind;
  } seq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

@@ hw/rtl/iafdp_iter.sv @@
// Shared shift-add / shift-subtract unit for multiply, divide and power.
module iafdp_iter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  iafdp_pkg::seq_ctrl_t                  ctrl,
  input  logic [iafdp_pkg::DataWidth-1:0]       opa,
  input  logic [iafdp_pkg::DataWidth-1:0]       opb,
  output iafdp_pkg::seq_stat_t                  stat,
  output logic [iafdp_pkg::DataWidth-1:0]       prod,
  output logic [iafdp_pkg::DataWidth-1:0]       quo,
  output logic [iafdp_pkg::DataWidth-1:0]       rem
);
  localparam int W = iafdp_pkg::DataWidth;

  iafdp_pkg::kind_t                   kind;
  logic                               busy;
  logic                               done;
  logic [iafdp_pkg::CountWidth-1:0]   cnt;
  logic                               phase;   // power: 0 multiply acc, 1 square base
  logic [W-1:0] acc, mc, mp;                   // multiply accumulator, multiplicand, multiplier
  logic [W-1:0] base, expo, pacc;              // power state
  logic [W-1:0] q, r;
  logic [W:0]   trial;
  logic         mul_done;

  // Divider step: shift in next dividend bit, subtract divisor when it fits.
  // mp holds the divisor for the whole divide.
  assign trial = {r, q[W-1]} - {1'b0, mp};
  assign mul_done = (cnt == iafdp_pkg::CountWidth'(W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        kind <= ctrl.kind;
        cnt  <= '0;
        acc  <= '0;
        mc   <= opa;
        mp   <= opb;
        q    <= opa;
        r    <= '0;
        base <= opa;
        expo <= opb;
        pacc <= {{(W-1){1'b0}}, 1'b1};
        phase <= 1'b0;
        if (ctrl.kind == iafdp_pkg::K_POW) begin
          mc <= {{(W-1){1'b0}}, 1'b1};
          mp <= opb[0] ? opa : {{(W-1){1'b0}}, 1'b1};
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        case (kind)
          iafdp_pkg::K_DIV: begin
            if (!trial[W]) r <= trial[W-1:0];
            else           r <= {r[W-2:0], q[W-1]};
            q <= {q[W-2:0], ~trial[W]};
            if (mul_done) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            // one shift-add step of mc * mp
            acc <= acc + (mp[0] ? mc : '0);
            mc  <= {mc[W-2:0], 1'b0};
            mp  <= {1'b0, mp[W-1:1]};
            if (mul_done) begin
              cnt <= '0;
              if (kind == iafdp_pkg::K_MUL) begin
                busy <= 1'b0;
                done <= 1'b1;
              end else if (!phase) begin
                // acc*base finished (or acc*1); now square the base
                pacc  <= acc + (mp[0] ? mc : '0);
                acc   <= '0;
                mc    <= base;
                mp    <= base;
                phase <= 1'b1;
              end else begin
                base <= acc + (mp[0] ? mc : '0);
                expo <= {1'b0, expo[W-1:1]};
                acc  <= '0;
                phase <= 1'b0;
                if (expo[W-1:1] == '0) begin
                  busy <= 1'b0;
                  done <= 1'b1;
                end else begin
                  mc <= pacc;
                  mp <= expo[1] ? (acc + (mp[0] ? mc : '0)) : {{(W-1){1'b0}}, 1'b1};
                end
              end
            end
          end
        endcase
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign prod = (kind == iafdp_pkg::K_POW) ? pacc : acc;
  assign quo  = q;
  assign rem  = r;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) stat.done |=> !stat.done)
    else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctrl.start |-> !busy)
    else $error("start while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) stat.done |-> !busy)
    else $error("done while busy");
endmodule

@@ hw/rtl/integer_alu_floor_div_power.sv @@
// Top level of the iterative 64-bit integer ALU.
//
//  channel | valid     | stall     | word
//  in      | in_valid  | in_stall  | operation, left_operand, right_operand
//  out     | out_valid | out_stall | result_value, result_is_boolean, status
//
// Simple operations present their result in the cycle after acceptance.
// Multiply and divide run on the shared shift unit; power takes two
// multiplies on it per exponent bit up to its top set bit.
// The input stalls while a word is in work or the result word waits.
// Reset (rst, synchronous) clears the sequencer and the output valid.
module integer_alu_floor_div_power (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  operation,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] result_value,
  output logic        result_is_boolean,
  output logic [1:0]  status
);
  localparam int W = iafdp_pkg::DataWidth;

  iafdp_pkg::state_t state, state_next;
  iafdp_pkg::seq_ctrl_t ctrl;
  iafdp_pkg::seq_stat_t stat;
  iafdp_pkg::kind_t kind_next;
  logic [4:0]   op;
  logic [W-1:0] a, b, prod, quo, rem, ua, ub;
  logic [W-1:0] val, val_next;
  logic         boo_next;
  iafdp_pkg::status_t st_next;
  logic         need_iter;
  logic [W-1:0] la, rb;
  logic [W-1:0] q_s, r_s, it_val;
  logic         take;

  assign take = in_valid && !in_stall;
  assign la = left_operand[W-1:0];
  assign rb = right_operand[W-1:0];
  assign in_stall = (state != iafdp_pkg::S_IDLE);

  // Classify the incoming word: errors and simple ops answer at once.
  always_comb begin
    val_next = '0;
    boo_next = 1'b0;
    st_next  = iafdp_pkg::ST_OK;
    need_iter = 1'b0;
    kind_next = iafdp_pkg::K_MUL;
    case (operation)
      iafdp_pkg::OP_ADD:  val_next = la + rb;
      iafdp_pkg::OP_SUB:  val_next = la - rb;
      iafdp_pkg::OP_MUL:  need_iter = 1'b1;
      iafdp_pkg::OP_MOD, iafdp_pkg::OP_FDIV: begin
        if (rb == '0) st_next = iafdp_pkg::ST_DIV_ZERO;
        else begin
          need_iter = 1'b1;
          kind_next = iafdp_pkg::K_DIV;
        end
      end
      iafdp_pkg::OP_AND:  val_next = la & rb;
      iafdp_pkg::OP_OR:   val_next = la | rb;
      iafdp_pkg::OP_XOR:  val_next = la ^ rb;
      iafdp_pkg::OP_NAND: val_next = ~(la & rb);
      iafdp_pkg::OP_XNOR: val_next = ~(la ^ rb);
      iafdp_pkg::OP_NOR:  val_next = ~(la | rb);
      iafdp_pkg::OP_SHL, iafdp_pkg::OP_SHR: begin
        if (rb >= W'(W)) st_next = iafdp_pkg::ST_SHIFT_RANGE;
        else if (operation == iafdp_pkg::OP_SHL) val_next = la << rb[5:0];
        else val_next = W'($signed(la) >>> rb[5:0]);
      end
      iafdp_pkg::OP_POW: begin
        if (rb[W-1]) st_next = iafdp_pkg::ST_NEEDS_FLOAT;
        else if (rb == '0) val_next = {{(W-1){1'b0}}, 1'b1};
        else begin
          need_iter = 1'b1;
          kind_next = iafdp_pkg::K_POW;
        end
      end
      iafdp_pkg::OP_LNAND: begin boo_next = 1'b1; val_next = W'(!((la != '0) && (rb != '0))); end
      iafdp_pkg::OP_LNOR:  begin boo_next = 1'b1; val_next = W'(!((la != '0) || (rb != '0))); end
      iafdp_pkg::OP_LXOR:  begin boo_next = 1'b1; val_next = W'((la != '0) != (rb != '0)); end
      iafdp_pkg::OP_LXNOR: begin boo_next = 1'b1; val_next = W'((la != '0) == (rb != '0)); end
      iafdp_pkg::OP_EQ: begin boo_next = 1'b1; val_next = W'(la == rb); end
      iafdp_pkg::OP_NE: begin boo_next = 1'b1; val_next = W'(la != rb); end
      iafdp_pkg::OP_LT: begin boo_next = 1'b1; val_next = W'($signed(la) < $signed(rb)); end
      iafdp_pkg::OP_LE: begin boo_next = 1'b1; val_next = W'($signed(la) <= $signed(rb)); end
      iafdp_pkg::OP_GT: begin boo_next = 1'b1; val_next = W'($signed(la) > $signed(rb)); end
      iafdp_pkg::OP_GE: begin boo_next = 1'b1; val_next = W'($signed(la) >= $signed(rb)); end
      iafdp_pkg::OP_DIV:
        st_next = (rb == '0) ? iafdp_pkg::ST_DIV_ZERO : iafdp_pkg::ST_NEEDS_FLOAT;
      default: ;
    endcase
  end

  // Divider runs on magnitudes; power and multiply on raw bits.
  assign ua = (kind_next == iafdp_pkg::K_DIV && la[W-1]) ? -la : la;
  assign ub = (kind_next == iafdp_pkg::K_DIV && rb[W-1]) ? -rb : rb;
  assign ctrl = '{start: take && need_iter, kind: kind_next};

  iafdp_iter u_iter (
    .clk(clk), .rst(rst), .ctrl(ctrl), .opa(ua), .opb(ub),
    .stat(stat), .prod(prod), .quo(quo), .rem(rem)
  );

  // Restore signs and apply the floor correction.
  assign q_s = (a[W-1] != b[W-1]) ? -quo : quo;
  assign r_s = a[W-1] ? -rem : rem;
  always_comb begin
    if (op == iafdp_pkg::OP_MOD) it_val = r_s;
    else if (op == iafdp_pkg::OP_FDIV)
      it_val = q_s - W'((rem != '0) && (a[W-1] != b[W-1]));
    else it_val = prod;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= iafdp_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      iafdp_pkg::S_IDLE:
        if (take) state_next = need_iter ? iafdp_pkg::S_RUN : iafdp_pkg::S_DONE;
      iafdp_pkg::S_RUN:
        if (stat.done) state_next = iafdp_pkg::S_DONE;
      iafdp_pkg::S_DONE:
        if (!out_stall) state_next = iafdp_pkg::S_IDLE;
      default: state_next = iafdp_pkg::S_IDLE;
    endcase
  end

  // Hold the word and the result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      op  <= operation;
      a   <= la;
      b   <= rb;
      val <= val_next;
      result_is_boolean <= boo_next;
      status <= st_next;
    end else if (stat.done) begin
      val <= it_val;
    end
  end

  assign out_valid    = (state == iafdp_pkg::S_DONE);
  assign result_value = val;

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != iafdp_pkg::S_IDLE |-> !take) else $error("word taken while busy");
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == iafdp_pkg::S_RUN) else $error("stray done");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != iafdp_pkg::ST_OK |-> result_value == '0 && !result_is_boolean)
    else $error("error word carries data");
endmodule
